FILE: sv/lsed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsed_pkg
// Shared constants and word types for the line-scan edge detector.
// ----------------------------------------------------------------------------
package lsed_pkg;

	// defaults for the top-level parameters
	localparam int DEF_LINE_LENGTH = 128;
	localparam int DEF_PIXEL_BITS  = 10;

	// field widths
	localparam int POS_BITS    = 7;
	localparam int GRAD_BITS   = 13;
	localparam int THRESH_BITS = 13;
	localparam int COUNT_BITS  = 2;

	// gradient scaling and the window where it is nonzero
	localparam int GRAD_SCALE = 10;
	localparam int GRAD_FIRST = 5;
	localparam int GRAD_LAST  = 120;
	localparam int GRAD_MAX   = (1 << GRAD_BITS) - 1;

	// window where runs are tracked
	localparam int RUN_FIRST = 1;
	localparam int RUN_LAST  = 126;

	// run counting and edge slots
	localparam int COUNT_MAX  = 3;
	localparam int EDGE_SLOTS = 4;

	localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(500);

	// classified word handed from the front to the back
	typedef struct packed {
		logic [POS_BITS-1:0]  position;
		logic [GRAD_BITS-1:0] gradient;
		logic                 above;
		logic                 in_run;
		logic                 last;
	} mid_item_t;

	// result word presented on the output ports
	typedef struct packed {
		logic [POS_BITS-1:0]   position;
		logic [GRAD_BITS-1:0]  gradient;
		logic                  line_done;
		logic [COUNT_BITS-1:0] edge_count;
		logic [POS_BITS-1:0]   slot_zero;
		logic [POS_BITS-1:0]   slot_one;
		logic [POS_BITS-1:0]   slot_two;
		logic [POS_BITS-1:0]   slot_three;
	} result_t;

endpackage
`default_nettype wire

FILE: sv/lsed_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsed_fifo
// Small synchronous word queue with registered storage and a
// first-word-fall-through head.
// ----------------------------------------------------------------------------
module lsed_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/lsed_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsed_front
// Takes pixels, keeps the two previous samples and the line position, forms
// the central-difference gradient and classifies it against the threshold.
// ----------------------------------------------------------------------------
module lsed_front #(
	parameter int LINE_LENGTH = lsed_pkg::DEF_LINE_LENGTH,
	parameter int PIXEL_BITS  = lsed_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire logic [PIXEL_BITS-1:0]               pixel,
	input  wire logic [lsed_pkg::THRESH_BITS-1:0]    threshold,
	output logic                                     item_push,
	output lsed_pkg::mid_item_t                      item
);

	localparam int PW   = $clog2(LINE_LENGTH);
	localparam int HW   = PIXEL_BITS - 1;
	localparam int GW   = PIXEL_BITS + 3;
	localparam int CW   = (GW > lsed_pkg::GRAD_BITS) ? GW : lsed_pkg::GRAD_BITS;

	logic [PIXEL_BITS-1:0] pixel_before_q;
	logic [PIXEL_BITS-1:0] pixel_two_before_q;
	logic [PW-1:0]         pos_q;

	logic          last_pix;
	logic [PW-1:0] j;
	logic [31:0]   j_wide;
	logic [HW-1:0] half_left;
	logic [HW-1:0] half_right;
	logic [HW-1:0] diff;
	logic [GW-1:0] grad_raw;
	logic          in_grad;
	logic [CW-1:0] grad_ext;
	logic [CW-1:0] thr_ext;

	// position of the result carried by this pixel
	assign last_pix = (pos_q == PW'(LINE_LENGTH - 1));
	assign j        = pos_q - PW'(1);
	assign j_wide   = 32'(j);

	// scaled absolute central difference of the halved neighbors
	assign half_left  = pixel_two_before_q[PIXEL_BITS-1:1];
	assign half_right = pixel[PIXEL_BITS-1:1];
	assign diff       = (half_left > half_right) ? (half_left - half_right)
	                                             : (half_right - half_left);
	assign grad_raw   = GW'(diff) * GW'(lsed_pkg::GRAD_SCALE);
	assign in_grad    = (int'(j) >= lsed_pkg::GRAD_FIRST) && (int'(j) <= lsed_pkg::GRAD_LAST);
	assign grad_ext   = in_grad ? CW'(grad_raw) : '0;
	assign thr_ext    = CW'(threshold);

	// classified word; no word for the first pixel of a line
	assign item_push = accept && (pos_q != '0);

	always_comb begin
		item          = '0;
		item.position = j_wide[lsed_pkg::POS_BITS-1:0];
		item.gradient = (grad_ext > CW'(lsed_pkg::GRAD_MAX))
		                ? lsed_pkg::GRAD_BITS'(lsed_pkg::GRAD_MAX)
		                : grad_ext[lsed_pkg::GRAD_BITS-1:0];
		item.above    = (grad_ext > thr_ext);
		item.in_run   = (int'(j) >= lsed_pkg::RUN_FIRST) && (int'(j) <= lsed_pkg::RUN_LAST);
		item.last     = last_pix;
	end

	// pixel history and line position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_before_q     <= '0;
			pixel_two_before_q <= '0;
			pos_q              <= '0;
		end else if (accept) begin
			pixel_two_before_q <= pixel_before_q;
			pixel_before_q     <= pixel;
			pos_q              <= last_pix ? '0 : pos_q + PW'(1);
		end
	end

endmodule
`default_nettype wire

FILE: sv/lsed_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsed_back
// Tracks above-threshold runs, records run end positions in the edge slots
// and, at the line end, folds the slots into midpoints for the result word.
// ----------------------------------------------------------------------------
module lsed_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	input  wire lsed_pkg::mid_item_t item,
	output logic                     item_pop,
	input  wire logic                res_ready,
	output logic                     res_push,
	output lsed_pkg::result_t        res
);

	localparam int PB = lsed_pkg::POS_BITS;
	localparam int CB = lsed_pkg::COUNT_BITS;

	logic          run_open_q;
	logic [CB-1:0] runs_found_q;
	logic [PB-1:0] slot_q [lsed_pkg::EDGE_SLOTS];

	logic          run_open_n;
	logic [CB-1:0] runs_found_n;
	logic [PB-1:0] slot_n [lsed_pkg::EDGE_SLOTS];
	logic [PB:0]   sum_lo;
	logic [PB:0]   sum_hi;

	assign item_pop = item_valid && res_ready;
	assign res_push = item_pop;

	// run detection, slot update and line-end fold
	always_comb begin
		run_open_n   = run_open_q;
		runs_found_n = runs_found_q;
		slot_n       = slot_q;
		res          = '0;
		sum_lo       = '0;
		sum_hi       = '0;

		if (item.in_run) begin
			if (item.above) begin
				run_open_n           = 1'b1;
				slot_n[runs_found_q] = item.position;
			end else begin
				if (run_open_q && (runs_found_q != CB'(lsed_pkg::COUNT_MAX))) begin
					runs_found_n = runs_found_q + CB'(1);
				end
				run_open_n = 1'b0;
			end
		end

		res.position  = item.position;
		res.gradient  = item.gradient;
		res.line_done = item.last;

		if (item.last) begin
			sum_lo         = {1'b0, slot_n[0]} + {1'b0, slot_n[1]};
			sum_hi         = {1'b0, slot_n[2]} + {1'b0, slot_n[3]};
			slot_n[0]      = sum_lo[PB:1];
			slot_n[1]      = sum_hi[PB:1];
			res.edge_count = runs_found_n;
			res.slot_zero  = slot_n[0];
			res.slot_one   = slot_n[1];
			res.slot_two   = slot_n[2];
			res.slot_three = slot_n[3];
			run_open_n     = 1'b0;
			runs_found_n   = '0;
		end
	end

	// run state and edge slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q   <= 1'b0;
			runs_found_q <= '0;
			for (int i = 0; i < lsed_pkg::EDGE_SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (item_pop) begin
			run_open_q   <= run_open_n;
			runs_found_q <= runs_found_n;
			slot_q       <= slot_n;
		end
	end

endmodule
`default_nettype wire

FILE: sv/line_scan_edge_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_scan_edge_detector
// Central-difference edge detector for a line-scan camera stream.
// ----------------------------------------------------------------------------
// Push one pixel per cycle starting at line position 0; the block takes a new
// pixel every cycle as long as results are popped. Each pixel after the first
// of a line yields one result word for the preceding position, which passes
// through a two-word queue between the classifying front and the run tracker
// and then a two-word result queue before it is available. The word for the
// last position of the line has line_done set and carries the run count and
// edge slots; these fields are zero otherwise. Edge slots persist across
// lines. Write edge_threshold only while no results are outstanding.
// ----------------------------------------------------------------------------
module line_scan_edge_detector #(
	parameter int LINE_LENGTH = lsed_pkg::DEF_LINE_LENGTH,
	parameter int PIXEL_BITS  = lsed_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// pixel input
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [PIXEL_BITS-1:0]            pixel,
	// result output
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [lsed_pkg::POS_BITS-1:0]         position,
	output logic [lsed_pkg::GRAD_BITS-1:0]        gradient,
	output logic                                  line_done,
	output logic [lsed_pkg::COUNT_BITS-1:0]       edge_count,
	output logic [lsed_pkg::POS_BITS-1:0]         edge_slot_zero,
	output logic [lsed_pkg::POS_BITS-1:0]         edge_slot_one,
	output logic [lsed_pkg::POS_BITS-1:0]         edge_slot_two,
	output logic [lsed_pkg::POS_BITS-1:0]         edge_slot_three,
	// configuration
	input  wire logic                             edge_threshold_wr,
	input  wire logic [lsed_pkg::THRESH_BITS-1:0] edge_threshold
);

	logic [lsed_pkg::THRESH_BITS-1:0] threshold_q;

	logic                accept;
	logic                mid_push;
	lsed_pkg::mid_item_t mid_in;
	lsed_pkg::mid_item_t mid_out;
	logic                mid_empty;
	logic                mid_pop;
	logic                res_full;
	logic                res_push;
	lsed_pkg::result_t   res_in;
	lsed_pkg::result_t   res_out;

	assign accept = push && !full;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= lsed_pkg::THRESH_RESET;
		end else if (edge_threshold_wr) begin
			threshold_q <= edge_threshold;
		end
	end

	// front: history, gradient, classification
	lsed_front #(
		.LINE_LENGTH (LINE_LENGTH),
		.PIXEL_BITS  (PIXEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pixel     (pixel),
		.threshold (threshold_q),
		.item_push (mid_push),
		.item      (mid_in)
	);

	// queue between front and back
	lsed_fifo #(
		.WIDTH ($bits(lsed_pkg::mid_item_t)),
		.DEPTH (2)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_in),
		.full    (full),
		.rd_en   (mid_pop),
		.rd_data (mid_out),
		.empty   (mid_empty)
	);

	// back: runs and edge slots
	lsed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!mid_empty),
		.item       (mid_out),
		.item_pop   (mid_pop),
		.res_ready  (!res_full),
		.res_push   (res_push),
		.res        (res_in)
	);

	// result queue
	lsed_fifo #(
		.WIDTH ($bits(lsed_pkg::result_t)),
		.DEPTH (2)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign position        = res_out.position;
	assign gradient        = res_out.gradient;
	assign line_done       = res_out.line_done;
	assign edge_count      = res_out.edge_count;
	assign edge_slot_zero  = res_out.slot_zero;
	assign edge_slot_one   = res_out.slot_one;
	assign edge_slot_two   = res_out.slot_two;
	assign edge_slot_three = res_out.slot_three;

	// line end lands on the last result position
	a_line_done_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && line_done) |-> (position == lsed_pkg::POS_BITS'(LINE_LENGTH - 2)))
		else $error("line_done on wrong position");

	// edge fields stay clear mid-line
	a_edge_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !line_done) |-> (edge_count == '0 && edge_slot_zero == '0 &&
		edge_slot_one == '0 && edge_slot_two == '0 && edge_slot_three == '0))
		else $error("edge fields set before line end");

	// gradient is gated near the line start
	a_grad_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (position < lsed_pkg::POS_BITS'(lsed_pkg::GRAD_FIRST))) |-> (gradient == '0))
		else $error("gradient not gated at line start");

	// back only advances when the result queue can take the word
	a_back_flow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> (res_push && !res_full))
		else $error("back consumed word without result slot");

endmodule
`default_nettype wire
